>>> rtl/assert_macros.svh
// Assertion macros shared by the row delta reconstruct RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication or plain property, sampled on the rising clock, off during reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition that must never be seen.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

>>> rtl/irdr_pkg.sv
// Package for the image row delta reconstruct block: payload types,
// register indexes and shared constants. No dependencies.
`default_nettype none

package irdr_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int WIDTH_W       = 13;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_EN    = 1'b1;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 13'd1;
   localparam logic [7:0]         ALPHA_OPAQUE = 8'hff;

   typedef struct packed {
      logic       frame_start;
      logic [7:0] blue_diff;
      logic [7:0] green_val;
      logic [7:0] red_diff;
      logic [7:0] alpha_val;
   } req_type;

   typedef struct packed {
      logic [7:0] alpha_out;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       row_end;
   } rsp_type;

   // Running-sum pixel and row flags handed from the front stage
   typedef struct packed {
      logic       first_row;
      logic       last;
      logic [7:0] sum_a;
      logic [7:0] sum_r;
      logic [7:0] sum_g;
      logic [7:0] sum_b;
   } pix_type;

endpackage

`default_nettype wire

>>> rtl/irdr_line_mem.sv
// Line store: one row of ARGB pixels, synchronous single write and single read port.
// Read data is registered. Depends on nothing.
`default_nettype none

module irdr_line_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/irdr_front.sv
// Front stage: column tracking, row start clearing and per-row running sums.
// Uses irdr_pkg types and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module irdr_front import irdr_pkg::*; #(
   parameter int COL_W = 12,
   parameter int CMP_W = 13
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire req_type          req,
   input  wire logic [CMP_W-1:0] width_eff,
   input  wire logic             alpha_en,
   output logic [COL_W-1:0]      col,
   output pix_type               pix
);

   logic [COL_W-1:0] col_ff, col_in;
   logic             first_ff, first_in;
   logic [7:0]       sum_b_ff, sum_g_ff, sum_r_ff, sum_a_ff;
   logic [COL_W-1:0] col_raw;
   logic             first_row;
   logic             row_start;
   logic             last;
   logic [7:0]       base_b, base_g, base_r, base_a;
   logic [7:0]       blue_c, red_c;

   // Column of this item, clamped to the current width
   always_comb begin
      col_raw   = req.frame_start ? '0 : col_ff;
      first_row = req.frame_start | first_ff;
      if (CMP_W'(col_raw) >= width_eff) begin
         col = COL_W'(width_eff - CMP_W'(1));
      end else begin
         col = col_raw;
      end
      last      = (CMP_W'(col) + CMP_W'(1)) >= width_eff;
      row_start = (col == '0);
   end

   // Color decorrelation and running sums
   always_comb begin
      blue_c = req.blue_diff + req.green_val;
      red_c  = req.red_diff + req.green_val;
      base_b = row_start ? 8'd0 : sum_b_ff;
      base_g = row_start ? 8'd0 : sum_g_ff;
      base_r = row_start ? 8'd0 : sum_r_ff;
      base_a = row_start ? 8'd0 : sum_a_ff;
      pix.first_row = first_row;
      pix.last      = last;
      pix.sum_b     = base_b + blue_c;
      pix.sum_g     = base_g + req.green_val;
      pix.sum_r     = base_r + red_c;
      pix.sum_a     = alpha_en ? base_a + req.alpha_val : base_a;
   end

   // Next column and row flag
   always_comb begin
      if (last) begin
         col_in   = '0;
         first_in = 1'b0;
      end else begin
         col_in   = col + COL_W'(1);
         first_in = first_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         first_ff <= 1'b1;
         sum_b_ff <= '0;
         sum_g_ff <= '0;
         sum_r_ff <= '0;
         sum_a_ff <= '0;
      end else if (accept) begin
         col_ff   <= col_in;
         first_ff <= first_in;
         sum_b_ff <= pix.sum_b;
         sum_g_ff <= pix.sum_g;
         sum_r_ff <= pix.sum_r;
         sum_a_ff <= pix.sum_a;
      end
   end

   // A finished row wraps to column zero and leaves the first row behind
   `ASSERT_PROP(a_row_wrap, clock, reset, (accept && last) |=> (col_ff == '0 && !first_ff))
   // A new image that does not end its row right away stays on its first row
   `ASSERT_PROP(a_frame_first, clock, reset, (accept && req.frame_start && !last) |=> first_ff)

endmodule

`default_nettype wire

>>> rtl/image_row_delta_reconstruct.sv
// Image row delta reconstruct: turns plane residual bytes into ARGB pixels.
// Top level; uses irdr_pkg, irdr_front, irdr_line_mem and assert_macros.svh.
//
// Usage:
//   req channel (valid/ready) takes one pixel per item: frame_start plus the
//   blue-diff, green, red-diff and alpha residual bytes. rsp channel gives one
//   ARGB pixel per item with row_end on the last pixel of each row.
//   csr port writes image_width (index 0) and alpha_plane_enable (index 1);
//   write only while no item is in flight.
// Timing:
//   An accepted item passes through the stage 1 register and then the output
//   register before it is offered on rsp. One item per cycle is sustained
//   while rsp_ready stays high; the line store has one read port (at acceptance)
//   and one write port (when the pixel moves to the output register), and a
//   forward path covers a read of the column being written in the same cycle.
// Reset:
//   Control state clears at once: column 0, first row, sums zero, width 1,
//   three-plane mode. The line store is not cleared; rows fill it as they pass.
// Stalls:
//   When rsp_ready is low the result is held in the output register, one more
//   item may sit in the stage behind it, and req_ready then drops.
`default_nettype none
`include "assert_macros.svh"

module image_row_delta_reconstruct import irdr_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int NEED_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = (NEED_W > WIDTH_W) ? NEED_W : WIDTH_W;

   logic [WIDTH_W-1:0] width_ff;
   logic               alpha_en_ff;
   logic [CMP_W-1:0]   width_eff;

   logic               req_accept;
   logic [COL_W-1:0]   front_col;
   pix_type            front_pix;

   logic               s1_vld_ff;
   logic [COL_W-1:0]   s1_col_ff;
   pix_type            s1_pix_ff;
   logic               s1_adv;
   logic               fwd_hit_ff;
   logic [31:0]        fwd_data_ff;

   logic [31:0]        rd_data;
   logic [31:0]        above;
   logic [31:0]        wr_data;
   rsp_type            s1_rsp;

   logic               rsp_vld_ff;
   rsp_type            rsp_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         alpha_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: width_ff    <= csr_wdata[WIDTH_W-1:0];
            CSR_ALPHA_EN:    alpha_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective width: zero means one, saturate at the line store depth
   always_comb begin
      if (width_ff == '0) begin
         width_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = CMP_W'(width_ff);
      end
   end

   // Handshake
   assign s1_adv     = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready  = !s1_vld_ff || s1_adv;
   assign req_accept = req_valid && req_ready;

   irdr_front #(
      .COL_W (COL_W),
      .CMP_W (CMP_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req       (req_data),
      .width_eff (width_eff),
      .alpha_en  (alpha_en_ff),
      .col       (front_col),
      .pix       (front_pix)
   );

   irdr_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (COL_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (front_col),
      .rd_data (rd_data),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data)
   );

   // Add the pixel above except on the first row, force alpha in three-plane mode
   always_comb begin
      above = fwd_hit_ff ? fwd_data_ff : rd_data;
      if (s1_pix_ff.first_row) begin
         s1_rsp.alpha_out = s1_pix_ff.sum_a;
         s1_rsp.red_out   = s1_pix_ff.sum_r;
         s1_rsp.green_out = s1_pix_ff.sum_g;
         s1_rsp.blue_out  = s1_pix_ff.sum_b;
      end else begin
         s1_rsp.alpha_out = s1_pix_ff.sum_a + above[31:24];
         s1_rsp.red_out   = s1_pix_ff.sum_r + above[23:16];
         s1_rsp.green_out = s1_pix_ff.sum_g + above[15:8];
         s1_rsp.blue_out  = s1_pix_ff.sum_b + above[7:0];
      end
      if (!alpha_en_ff) begin
         s1_rsp.alpha_out = ALPHA_OPAQUE;
      end
      s1_rsp.row_end = s1_pix_ff.last;
      wr_data = {s1_rsp.alpha_out, s1_rsp.red_out, s1_rsp.green_out, s1_rsp.blue_out};
   end

   // Stage 1 control; forward when the read hits the column written this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else if (req_accept) begin
         s1_vld_ff  <= 1'b1;
         fwd_hit_ff <= s1_vld_ff && (s1_col_ff == front_col);
      end else if (s1_adv) begin
         s1_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff   <= front_col;
         s1_pix_ff   <= front_pix;
         fwd_data_ff <= wr_data;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= s1_rsp;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // A forward only comes with a pixel waiting in stage 1
   `ASSERT_PROP(a_fwd_owner, clock, reset, fwd_hit_ff |-> s1_vld_ff)
   // Line store writes stay inside the current row
   `ASSERT_NEVER(a_wr_range, clock, reset, s1_adv && (CMP_W'(s1_col_ff) >= width_eff))

endmodule

`default_nettype wire
